FILE: rtl/tsrs_pkg.sv
`timescale 1ns / 1ps

package tsrs_pkg;

  // Item kinds carried on in_tuser
  localparam logic [1:0] OP_CLEAR      = 2'd0;
  localparam logic [1:0] OP_APPEND     = 2'd1;
  localparam logic [1:0] OP_SORT_RANK  = 2'd2;
  localparam logic [1:0] OP_SORT_LEVEL = 2'd3;

  localparam int unsigned KeyW  = 16;
  localparam int unsigned DataW = 48;

  // One member record, tag in the lowest bits
  typedef struct packed {
    logic        online;
    logic [15:0] level;
    logic [7:0]  rank;
    logic [15:0] tag;
  } rec_t;

  // Control of the shared compare/count unit
  typedef struct packed {
    logic clr;         // restart the count for a new record
    logic en;          // a stored record is presented for compare
    logic by_level;    // key select
    logic descending;  // direction of this sort
    logic earlier;     // presented record sits before the current one
  } rank_ctl_t;

  function automatic logic [KeyW-1:0] key_of(input rec_t r, input logic by_level);
    logic [KeyW-1:0] k;
    k = by_level ? r.level : {8'd0, r.rank};
    return k;
  endfunction

endpackage

FILE: rtl/tsrs_rank_unit.sv
`timescale 1ns / 1ps

// Shared compare unit: counts how many stored records go ahead of the
// current one in a stable sort, one compare per cycle while ctl.en is set.
module tsrs_rank_unit #(
  parameter int unsigned AW = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tsrs_pkg::rank_ctl_t ctl,
  input  tsrs_pkg::rec_t      cur,
  input  tsrs_pkg::rec_t      other,
  output logic [AW-1:0]       pos
);

  logic [tsrs_pkg::KeyW-1:0] key_c;
  logic [tsrs_pkg::KeyW-1:0] key_o;
  logic                      ahead;
  logic [AW-1:0]             cnt_r;
  logic [AW-1:0]             cnt_nxt;

  // other goes first if its key strictly wins, or ties and it came earlier
  always_comb begin
    key_c = tsrs_pkg::key_of(cur, ctl.by_level);
    key_o = tsrs_pkg::key_of(other, ctl.by_level);
    if (key_o == key_c) begin
      ahead = ctl.earlier;
    end else if (ctl.descending) begin
      ahead = key_o > key_c;
    end else begin
      ahead = key_o < key_c;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.clr) begin
      cnt_nxt = '0;
    end else if (ctl.en && ahead) begin
      cnt_nxt = cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign pos = cnt_r;

endmodule

FILE: rtl/toggled_stable_record_sorter.sv
`timescale 1ns / 1ps

// Channel  Dir  Ports                         Contents
// in_      in   tvalid tready tdata tuser     one command word, kind on tuser
// out_     out  tvalid tready tdata tlast     one record word of a sorted listing
//
// Clear and append are taken while idle and leave the block idle. A sort of n
// records ranks every record in turn (one compare per cycle in the shared
// unit, one store read port), then emits and writes back each record in order,
// waiting on output stalls; in_tready is low throughout. A sort of an empty
// store stays idle. Reset (rst_n low, synchronous) empties the store and sets
// both directions to descending; the store memory itself is not cleared.
module toggled_stable_record_sorter #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [tsrs_pkg::DataW-1:0] in_tdata,  // tag[15:0] rank[23:16] level[39:24] online[40]
  input  logic [1:0]                 in_tuser,  // op[1:0]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [tsrs_pkg::DataW-1:0] out_tdata, // tag[15:0] rank[23:16] level[39:24] online[40]
  output logic                       out_tlast
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_LATCH, S_SCAN, S_PLACE, S_ERD, S_EWR, S_EWAIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 rank_desc_r, rank_desc_nxt;
  logic                 level_desc_r, level_desc_nxt;
  logic                 by_level_r, by_level_nxt;
  logic                 desc_r, desc_nxt;
  logic [CW-1:0]        n_r, n_nxt;
  logic [CW-1:0]        i_r, i_nxt;
  logic [CW-1:0]        j_r, j_nxt;
  logic                 cvld_r, cvld_nxt;
  logic [CW-1:0]        cidx_r, cidx_nxt;
  logic [CW-1:0]        e_r, e_nxt;
  tsrs_pkg::rec_t       cur_r, cur_nxt;
  logic                 out_valid_r, out_valid_nxt;
  tsrs_pkg::rec_t       out_rec_r, out_rec_nxt;
  logic                 out_last_r, out_last_nxt;

  // Memories
  tsrs_pkg::rec_t       store_mem [MAX_ENTRIES];
  tsrs_pkg::rec_t       scr_mem   [MAX_ENTRIES];
  logic                 st_we;
  logic [AW-1:0]        st_waddr;
  tsrs_pkg::rec_t       st_wdata;
  logic [AW-1:0]        st_raddr;
  tsrs_pkg::rec_t       st_rdata_r;
  logic                 scr_we;
  tsrs_pkg::rec_t       scr_rdata_r;

  tsrs_pkg::rank_ctl_t  rctl;
  logic [AW-1:0]        pos;
  logic                 in_acc;
  tsrs_pkg::rec_t       in_rec;

  assign in_acc = in_tvalid && in_tready;
  assign in_rec = tsrs_pkg::rec_t'(in_tdata[40:0]);

  tsrs_rank_unit #(.AW(AW)) u_rank (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rctl),
    .cur   (cur_r),
    .other (st_rdata_r),
    .pos   (pos)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rank_desc_nxt  = rank_desc_r;
    level_desc_nxt = level_desc_r;
    by_level_nxt   = by_level_r;
    desc_nxt       = desc_r;
    n_nxt          = n_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    cvld_nxt       = cvld_r;
    cidx_nxt       = cidx_r;
    e_nxt          = e_r;
    cur_nxt        = cur_r;
    out_valid_nxt  = out_valid_r;
    out_rec_nxt    = out_rec_r;
    out_last_nxt   = out_last_r;
    st_we          = 1'b0;
    st_waddr       = count_r[AW-1:0];
    st_wdata       = in_rec;
    st_raddr       = i_r[AW-1:0];
    scr_we         = 1'b0;
    rctl.clr        = 1'b0;
    rctl.en         = 1'b0;
    rctl.by_level   = by_level_r;
    rctl.descending = desc_r;
    rctl.earlier    = cidx_r < i_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            tsrs_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            tsrs_pkg::OP_APPEND: begin
              if (count_r < CW'(MAX_ENTRIES)) begin
                st_we     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            tsrs_pkg::OP_SORT_RANK: begin
              by_level_nxt  = 1'b0;
              desc_nxt      = rank_desc_r;
              rank_desc_nxt = !rank_desc_r;
              n_nxt         = count_r;
              i_nxt         = '0;
              if (count_r != '0) begin
                state_nxt = S_LOAD;
              end
            end
            default: begin
              by_level_nxt   = 1'b1;
              desc_nxt       = level_desc_r;
              level_desc_nxt = !level_desc_r;
              n_nxt          = count_r;
              i_nxt          = '0;
              if (count_r != '0) begin
                state_nxt = S_LOAD;
              end
            end
          endcase
        end
      end
      S_LOAD: begin
        st_raddr  = i_r[AW-1:0];
        state_nxt = S_LATCH;
      end
      S_LATCH: begin
        cur_nxt   = st_rdata_r;
        rctl.clr  = 1'b1;
        j_nxt     = '0;
        cvld_nxt  = 1'b0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // issue read j, compare the word read last cycle
        if (j_r < n_r) begin
          st_raddr = j_r[AW-1:0];
          j_nxt    = j_r + CW'(1);
          cvld_nxt = 1'b1;
          cidx_nxt = j_r;
        end else begin
          cvld_nxt = 1'b0;
        end
        rctl.en = cvld_r;
        if (cvld_r && (cidx_r == n_r - CW'(1))) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        scr_we = 1'b1;
        if (i_r + CW'(1) == n_r) begin
          e_nxt     = '0;
          state_nxt = S_ERD;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_LOAD;
        end
      end
      S_ERD: begin
        state_nxt = S_EWR;
      end
      S_EWR: begin
        // write the sorted order back and present the word
        st_we         = 1'b1;
        st_waddr      = e_r[AW-1:0];
        st_wdata      = scr_rdata_r;
        out_rec_nxt   = scr_rdata_r;
        out_last_nxt  = e_r == n_r - CW'(1);
        out_valid_nxt = 1'b1;
        state_nxt     = S_EWAIT;
      end
      S_EWAIT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (e_r + CW'(1) == n_r) begin
            state_nxt = S_IDLE;
          end else begin
            e_nxt     = e_r + CW'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      rank_desc_r  <= 1'b1;
      level_desc_r <= 1'b1;
      by_level_r   <= 1'b0;
      desc_r       <= 1'b1;
      n_r          <= '0;
      i_r          <= '0;
      j_r          <= '0;
      cvld_r       <= 1'b0;
      cidx_r       <= '0;
      e_r          <= '0;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      rank_desc_r  <= rank_desc_nxt;
      level_desc_r <= level_desc_nxt;
      by_level_r   <= by_level_nxt;
      desc_r       <= desc_nxt;
      n_r          <= n_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      cvld_r       <= cvld_nxt;
      cidx_r       <= cidx_nxt;
      e_r          <= e_nxt;
      out_valid_r  <= out_valid_nxt;
      out_last_r   <= out_last_nxt;
    end
    cur_r     <= cur_nxt;
    out_rec_r <= out_rec_nxt;
  end

  // Record store: one write, one registered read
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_waddr] <= st_wdata;
    end
    st_rdata_r <= store_mem[st_raddr];
  end

  // Sorted scratch: written at the rank found, read in order
  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[pos] <= cur_r;
    end
    scr_rdata_r <= scr_mem[e_r[AW-1:0]];
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_rec_r};
  assign out_tlast  = out_last_r;

  // A result never waits while a new command can be taken
  a_out_blocks_in : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("command accepted while a record is pending");

  // The rank found always lands inside the listing
  a_pos_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLACE) |-> (CW'(pos) < n_r))
    else $error("sorted position beyond record count");

  // Last marker only on the final record of the listing
  a_last_final : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (e_r == n_r - CW'(1)))
    else $error("last marker on wrong record");

  // A sort of an empty store leaves the block ready
  a_empty_sort : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[1] && (count_r == '0)) |=> in_tready)
    else $error("empty sort did not return to idle");

  // Store never grows past its depth
  a_count_max : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == tsrs_pkg::OP_APPEND)) |=> (count_r <= CW'(MAX_ENTRIES)))
    else $error("record count overflow");

endmodule

FILE: bench/toggled_stable_record_sorter_test.sv
`timescale 1ns / 1ps

module toggled_stable_record_sorter_test;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned RAND_WORDS = 160;

  // How a directed row is checked
  typedef enum logic [1:0] {
    USE_MODEL,
    TYPED_NONE,
    TYPED_ONE
  } check_t;

  typedef struct packed {
    logic [1:0]     op;
    tsrs_pkg::rec_t rec;
    check_t         check;
    tsrs_pkg::rec_t want;
  } step_t;

  typedef struct packed {
    tsrs_pkg::rec_t rec;
    logic           last;
  } listing_t;

  function automatic tsrs_pkg::rec_t make_rec(input logic [15:0] tag, input logic [7:0] rank,
                                              input logic [15:0] level, input logic online);
    tsrs_pkg::rec_t r;
    r.tag    = tag;
    r.rank   = rank;
    r.level  = level;
    r.online = online;
    return r;
  endfunction

  // Directed rows: empty sorts, extremes, ties in both keys, both directions
  localparam step_t STEPS[22] = '{
    '{tsrs_pkg::OP_SORT_RANK,  '0, TYPED_NONE, '0},
    '{tsrs_pkg::OP_SORT_LEVEL, '0, TYPED_NONE, '0},
    '{tsrs_pkg::OP_APPEND, make_rec(16'hFFFF, 8'hFF, 16'hFFFF, 1'b1), TYPED_NONE, '0},
    '{tsrs_pkg::OP_SORT_RANK,  '0, TYPED_ONE, make_rec(16'hFFFF, 8'hFF, 16'hFFFF, 1'b1)},
    '{tsrs_pkg::OP_CLEAR,      '0, TYPED_NONE, '0},
    '{tsrs_pkg::OP_APPEND,     '0, TYPED_NONE, '0},
    '{tsrs_pkg::OP_SORT_LEVEL, '0, TYPED_ONE, '0},
    '{tsrs_pkg::OP_CLEAR,      '0, TYPED_NONE, '0},
    '{tsrs_pkg::OP_APPEND, make_rec(16'h0001, 8'h05, 16'h0064, 1'b0), TYPED_NONE, '0},
    '{tsrs_pkg::OP_APPEND, make_rec(16'h0002, 8'h05, 16'h00C8, 1'b1), TYPED_NONE, '0},
    '{tsrs_pkg::OP_APPEND, make_rec(16'h0003, 8'h09, 16'h0064, 1'b0), TYPED_NONE, '0},
    '{tsrs_pkg::OP_APPEND, make_rec(16'h0004, 8'h00, 16'hFFFF, 1'b1), TYPED_NONE, '0},
    '{tsrs_pkg::OP_APPEND, make_rec(16'h0005, 8'hFF, 16'h0000, 1'b0), TYPED_NONE, '0},
    '{tsrs_pkg::OP_APPEND, make_rec(16'h0006, 8'h05, 16'h0064, 1'b1), TYPED_NONE, '0},
    '{tsrs_pkg::OP_SORT_RANK,  '0, USE_MODEL, '0},
    '{tsrs_pkg::OP_SORT_RANK,  '0, USE_MODEL, '0},
    '{tsrs_pkg::OP_SORT_LEVEL, '0, USE_MODEL, '0},
    '{tsrs_pkg::OP_SORT_LEVEL, '0, USE_MODEL, '0},
    '{tsrs_pkg::OP_APPEND, make_rec(16'hA5A5, 8'h80, 16'h8000, 1'b1), TYPED_NONE, '0},
    '{tsrs_pkg::OP_SORT_LEVEL, '0, USE_MODEL, '0},
    '{tsrs_pkg::OP_CLEAR,      '0, TYPED_NONE, '0},
    '{tsrs_pkg::OP_SORT_RANK,  '0, TYPED_NONE, '0}
  };

  logic                       clk;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [tsrs_pkg::DataW-1:0] in_tdata;
  logic [1:0]                 in_tuser;
  logic                       out_tvalid;
  logic                       out_tready;
  logic [tsrs_pkg::DataW-1:0] out_tdata;
  logic                       out_tlast;

  toggled_stable_record_sorter #(
    .MAX_ENTRIES(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Predicted state of the member list
  tsrs_pkg::rec_t rec_store[DEPTH];
  int unsigned    rec_count;
  logic           rank_desc;
  logic           level_desc;

  listing_t listing_q[$];  // listing caused by the latest word
  listing_t pending_q[$];  // listing words still owed by the block

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          failed;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  // Queue one listing word as owed by the block
  function automatic void owe_word(input listing_t w);
    pending_q.insert(pending_q.size(), w);
  endfunction

  function automatic logic [15:0] sort_key(input tsrs_pkg::rec_t r, input logic by_level);
    return by_level ? r.level : {8'd0, r.rank};
  endfunction

  // Models clear and append; a sort is a stable insertion sort whose order becomes the stored order
  function automatic void predict_word(input logic [1:0] op, input tsrs_pkg::rec_t rec);
    tsrs_pkg::rec_t ordered[$];
    logic           by_level;
    logic           desc;
    logic [15:0]    k;
    logic [15:0]    e;
    int             pos;
    listing_q.delete();
    case (op)
      tsrs_pkg::OP_CLEAR: rec_count = 0;
      tsrs_pkg::OP_APPEND: begin
        if (rec_count < DEPTH) begin
          rec_store[rec_count] = rec;
          rec_count++;
        end
      end
      default: begin
        by_level = (op == tsrs_pkg::OP_SORT_LEVEL);
        desc     = by_level ? level_desc : rank_desc;
        for (int i = 0; i < rec_count; i++) begin
          k   = sort_key(rec_store[i], by_level);
          pos = ordered.size();
          for (int j = 0; j < ordered.size(); j++) begin
            e = sort_key(ordered[j], by_level);
            if (desc ? (k > e) : (k < e)) begin
              pos = j;
              break;
            end
          end
          ordered.insert(pos, rec_store[i]);
        end
        for (int i = 0; i < rec_count; i++) begin
          rec_store[i] = ordered[i];
          listing_q.insert(listing_q.size(),
                           listing_t'{rec: ordered[i], last: (i == rec_count - 1)});
        end
        if (by_level) level_desc = ~level_desc;
        else rank_desc = ~rank_desc;
      end
    endcase
  endfunction

  // Drive one command word, with random idle cycles ahead of it
  task automatic send_word(input logic [1:0] op, input tsrs_pkg::rec_t rec);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(tsrs_pkg::DataW - $bits(tsrs_pkg::rec_t)){1'b0}}, rec};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic issue_word(input logic [1:0] op, input tsrs_pkg::rec_t rec);
    send_word(op, rec);
    predict_word(op, rec);
    foreach (listing_q[i]) owe_word(listing_q[i]);
  endtask

  // Keys drawn from a narrow range half the time so that ties are common
  function automatic tsrs_pkg::rec_t rand_rec();
    return make_rec(16'($urandom_range(0, 65535)),
                    8'($urandom_range(1) ? $urandom_range(0, 3) : $urandom_range(0, 255)),
                    16'($urandom_range(1) ? $urandom_range(0, 3) : $urandom_range(0, 65535)),
                    1'($urandom_range(1)));
  endfunction

  function automatic void set_phase(input int unsigned phase);
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
      default: begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
  endfunction

  // Receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each listing word with the oldest prediction
  listing_t       want;
  tsrs_pkg::rec_t got;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected listing word: tdata %h tlast %b", out_tdata, out_tlast);
        failed = 1'b1;
      end else begin
        want = pending_q.pop_front();
        got  = tsrs_pkg::rec_t'(out_tdata[$bits(tsrs_pkg::rec_t)-1:0]);
        if (got.tag !== want.rec.tag) begin
          $error("tag: expected %h, got %h", want.rec.tag, got.tag);
          failed = 1'b1;
        end
        if (got.rank !== want.rec.rank) begin
          $error("rank: expected %h, got %h", want.rec.rank, got.rank);
          failed = 1'b1;
        end
        if (got.level !== want.rec.level) begin
          $error("level: expected %h, got %h", want.rec.level, got.level);
          failed = 1'b1;
        end
        if (got.online !== want.rec.online) begin
          $error("online: expected %b, got %b", want.rec.online, got.online);
          failed = 1'b1;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_tlast);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned n_recs;
    int unsigned big_runs;
    logic [1:0]  op;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = tsrs_pkg::OP_CLEAR;
    out_tready = 1'b0;
    failed     = 1'b0;
    rec_count  = 0;
    rank_desc  = 1'b1;
    level_desc = 1'b1;
    big_runs   = 0;
    sent       = 0;
    set_phase(0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows
    foreach (STEPS[i]) begin
      send_word(STEPS[i].op, STEPS[i].rec);
      predict_word(STEPS[i].op, STEPS[i].rec);
      case (STEPS[i].check)
        USE_MODEL: foreach (listing_q[j]) owe_word(listing_q[j]);
        TYPED_ONE: owe_word(listing_t'{rec: STEPS[i].want, last: 1'b1});
        default: ;
      endcase
    end

    // Random runs: build a list, sort it a few times, with some stray words
    while (sent < RAND_WORDS) begin
      set_phase(sent * 4 / RAND_WORDS);
      if ($urandom_range(7) != 0) begin
        issue_word(tsrs_pkg::OP_CLEAR, rand_rec());
        sent++;
      end
      if (big_runs < 2 && $urandom_range(11) == 0) begin
        n_recs = DEPTH + $urandom_range(0, 3);
        big_runs++;
      end else begin
        n_recs = $urandom_range(0, 10);
      end
      repeat (n_recs) begin
        if (rec_count < DEPTH) sent++;
        issue_word(tsrs_pkg::OP_APPEND, rand_rec());
        if ($urandom_range(15) == 0) begin
          op = 2'($urandom_range(0, 3));
          if (op != tsrs_pkg::OP_APPEND || rec_count < DEPTH) sent++;
          issue_word(op, rand_rec());
        end
      end
      repeat ($urandom_range(1, 3)) begin
        issue_word($urandom_range(1) ? tsrs_pkg::OP_SORT_RANK : tsrs_pkg::OP_SORT_LEVEL,
                   rand_rec());
        sent++;
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (!failed && pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
